[hw/rtl/psg_pkg.sv]
package psg_pkg;

  typedef enum logic [2:0] {
    PSG_TICK      = 3'd0,
    PSG_SELECT    = 3'd1,
    PSG_WRITE     = 3'd2,
    PSG_READ      = 3'd3,
    PSG_IRQ_ENTER = 3'd4,
    PSG_IRQ_EXIT  = 3'd5
  } psg_func_e;

  typedef enum logic [1:0] {
    PSG_FALL = 2'd0,
    PSG_RISE = 2'd1,
    PSG_LOW  = 2'd2,
    PSG_HIGH = 2'd3
  } psg_kind_e;

  localparam int unsigned NumVoices = 3;
  localparam int unsigned RegCount  = 14;
  localparam int unsigned RegIdxW   = 4;
  localparam int unsigned ToneW     = 12;
  localparam int unsigned ToneCntW  = 13;
  localparam int unsigned NoiseW    = 5;
  localparam int unsigned NoiseCntW = 6;
  localparam int unsigned LfsrW     = 17;
  localparam int unsigned EnvW      = 16;
  localparam int unsigned EnvCntW   = 17;
  localparam int unsigned EnvPosW   = 6;
  localparam int unsigned LevelW    = 4;

  localparam logic [RegIdxW-1:0] REG_NOISE      = 4'd6;
  localparam logic [RegIdxW-1:0] REG_MIXER      = 4'd7;
  localparam logic [RegIdxW-1:0] REG_VOL_A      = 4'd8;
  localparam logic [RegIdxW-1:0] REG_ENV_FINE   = 4'd11;
  localparam logic [RegIdxW-1:0] REG_ENV_COARSE = 4'd12;
  localparam logic [RegIdxW-1:0] REG_ENV_SHAPE  = 4'd13;

  localparam logic [7:0] MIXER_RESET = 8'h3f;

  typedef struct packed {
    logic tick;
    logic half_tick;
    logic irq_exit;
    logic env_restart;
  } psg_ctrl_t;

  function automatic logic [7:0] reg_mask(logic [RegIdxW-1:0] idx);
    logic [7:0] m;
    unique case (idx)
      4'd0, 4'd2, 4'd4, 4'd11, 4'd12: m = 8'hff;
      4'd1, 4'd3, 4'd5, 4'd13:        m = 8'h0f;
      4'd6, 4'd8, 4'd9, 4'd10:        m = 8'h1f;
      4'd7:                           m = 8'h3f;
      default:                        m = 8'h00;
    endcase
    return m;
  endfunction

  // First phase is a ramp set by the attack bit; the second depends on the whole shape.
  function automatic psg_kind_e shape_kind(logic [3:0] shape, logic phase);
    psg_kind_e k;
    if (!phase) begin
      k = shape[2] ? PSG_RISE : PSG_FALL;
    end else begin
      unique case (shape)
        4'd8, 4'd14:  k = PSG_FALL;
        4'd10, 4'd12: k = PSG_RISE;
        4'd11, 4'd13: k = PSG_HIGH;
        default:      k = PSG_LOW;
      endcase
    end
    return k;
  endfunction

  function automatic logic [LevelW-1:0] env_level(psg_kind_e kind, logic [4:0] step);
    logic [LevelW-1:0] l;
    unique case (kind)
      PSG_FALL: l = ~step[4:1];
      PSG_RISE: l = step[4:1];
      PSG_LOW:  l = '0;
      PSG_HIGH: l = '1;
      default:  l = '0;
    endcase
    return l;
  endfunction

endpackage

[hw/rtl/psg_tone.sv]
module psg_tone (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  psg_pkg::psg_ctrl_t                           ctrl_i,
  input  logic [psg_pkg::NumVoices-1:0][psg_pkg::ToneW-1:0] period_i,
  input  logic [psg_pkg::NumVoices-1:0]                sync_set_i,
  output logic [psg_pkg::NumVoices-1:0]                edges_o
);

  logic [psg_pkg::ToneCntW-1:0] cnt_q [psg_pkg::NumVoices];
  logic [psg_pkg::ToneCntW-1:0] cnt_d [psg_pkg::NumVoices];
  logic [psg_pkg::ToneCntW-1:0] inc   [psg_pkg::NumVoices];
  logic [psg_pkg::NumVoices-1:0] edges_q, edges_d;
  logic [psg_pkg::NumVoices-1:0] pending_q, pending_d;

  always_comb begin
    edges_d   = edges_q;
    pending_d = ctrl_i.irq_exit ? '0 : (pending_q | sync_set_i);
    for (int v = 0; v < psg_pkg::NumVoices; v++) begin
      inc[v]   = cnt_q[v] + psg_pkg::ToneCntW'(1);
      cnt_d[v] = cnt_q[v];
      if (ctrl_i.tick) begin
        if (inc[v] >= {1'b0, period_i[v]}) begin
          edges_d[v] = ~edges_q[v];
          cnt_d[v]   = '0;
        end else begin
          cnt_d[v] = inc[v];
        end
      end else if (ctrl_i.irq_exit && pending_q[v]) begin
        // Square sync: restart the voice with a forced phase flip.
        edges_d[v] = ~edges_q[v];
        cnt_d[v]   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edges_q   <= '0;
      pending_q <= '0;
      for (int v = 0; v < psg_pkg::NumVoices; v++) begin
        cnt_q[v] <= '0;
      end
    end else begin
      edges_q   <= edges_d;
      pending_q <= pending_d;
      for (int v = 0; v < psg_pkg::NumVoices; v++) begin
        cnt_q[v] <= cnt_d[v];
      end
    end
  end

  assign edges_o = edges_q;

  a_exit_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.irq_exit |=> pending_q == '0)
    else $error("sync request survived an interrupt exit");

  a_edges_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.tick || ctrl_i.irq_exit) |=> $stable(edges_q))
    else $error("tone phase moved without a tick or interrupt exit");

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.tick |=> cnt_q[0] <= psg_pkg::ToneCntW'(4096))
    else $error("tone counter ran past the largest period");

endmodule

[hw/rtl/psg_noise.sv]
module psg_noise (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  psg_pkg::psg_ctrl_t           ctrl_i,
  input  logic [psg_pkg::NoiseW-1:0]   period_i,
  output logic                         noise_bit_o
);

  logic [psg_pkg::NoiseCntW-1:0] cnt_q, cnt_d, inc;
  logic [psg_pkg::LfsrW-1:0]     shift_q, shift_d;
  logic                          bit_q, bit_d, fb;

  always_comb begin
    inc     = cnt_q + psg_pkg::NoiseCntW'(1);
    fb      = shift_q[0] ^ shift_q[2];
    cnt_d   = cnt_q;
    shift_d = shift_q;
    bit_d   = bit_q;
    if (ctrl_i.half_tick) begin
      if (inc >= {1'b0, period_i}) begin
        cnt_d   = '0;
        bit_d   = fb;
        shift_d = {fb, shift_q[psg_pkg::LfsrW-1:1]};
      end else begin
        cnt_d = inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      shift_q <= psg_pkg::LfsrW'(1);
      bit_q   <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      bit_q   <= bit_d;
    end
  end

  assign noise_bit_o = bit_q;

  a_lfsr_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_q != '0)
    else $error("noise shift register locked up at zero");

  a_noise_only_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.half_tick |=> $stable(shift_q) && $stable(cnt_q))
    else $error("noise state moved outside a half-rate tick");

  a_bit_from_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(shift_q) != shift_q |-> bit_q == shift_q[psg_pkg::LfsrW-1])
    else $error("noise output differs from the bit shifted in");

endmodule

[hw/rtl/psg_env.sv]
module psg_env (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  psg_pkg::psg_ctrl_t           ctrl_i,
  input  logic [psg_pkg::EnvW-1:0]     period_i,
  input  logic [3:0]                   shape_i,
  output logic [psg_pkg::LevelW-1:0]   level_o
);

  logic [psg_pkg::EnvCntW-1:0] cnt_q, cnt_d, inc;
  // Position 0..63: values below 32 are the first phase of the shape.
  logic [psg_pkg::EnvPosW-1:0] pos_q, pos_d;
  logic                        repeating;

  assign repeating = shape_i[3] & ~shape_i[0];

  always_comb begin
    inc   = cnt_q + psg_pkg::EnvCntW'(1);
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (ctrl_i.env_restart) begin
      cnt_d = '0;
      pos_d = '0;
    end else if (ctrl_i.half_tick) begin
      if (inc >= {1'b0, period_i}) begin
        cnt_d = '0;
        if (pos_q == '1) begin
          pos_d = repeating ? '0 : psg_pkg::EnvPosW'(32);
        end else begin
          pos_d = pos_q + psg_pkg::EnvPosW'(1);
        end
      end else begin
        cnt_d = inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= psg_pkg::EnvPosW'(32);
    end else begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
    end
  end

  assign level_o = psg_pkg::env_level(psg_pkg::shape_kind(shape_i, pos_q[5]), pos_q[4:0]);

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.env_restart |=> pos_q == '0 && cnt_q == '0)
    else $error("envelope did not restart on a shape write");

  a_hold_second_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q[5] && !ctrl_i.env_restart && !repeating |=> pos_q[5])
    else $error("hold shape left its second phase");

  a_env_only_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.half_tick && !ctrl_i.env_restart |=> $stable(pos_q) && $stable(cnt_q))
    else $error("envelope moved outside a half-rate tick");

endmodule

[hw/rtl/psg_three_voice_tone_noise_envelope.sv]
// Three-voice sound generator core with tone, noise and envelope, driven one port
// access per item (tick, register select, data write, data read, interrupt enter
// and exit), each giving exactly one result. A new item is taken every clock
// cycle unless the input is stalled; the item is held in an input register and
// is then loaded into a result register that drives the outputs, and all counters,
// the noise shift register and the envelope advance at that same edge. A stalled
// result holds the input register and stalls the input. Levels on a tick
// reflect the state before that tick's update. Reads of register numbers 14
// and above return zero, and writes to them are dropped.
module psg_three_voice_tone_noise_envelope (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] func_i,
  input  logic [7:0] value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] level_a_o,
  output logic [3:0] level_b_o,
  output logic [3:0] level_c_o,
  output logic [7:0] read_data_o
);

  logic       in_valid_q;
  logic [2:0] func_q;
  logic [7:0] value_q;
  logic       adv, exec;

  logic       out_valid_q;
  logic [3:0] level_a_q, level_b_q, level_c_q;
  logic [7:0] read_data_q;

  logic [7:0] regs_q [psg_pkg::RegCount];
  logic [7:0] regs_d [psg_pkg::RegCount];
  logic [7:0] sel_q, sel_d;
  logic       in_irq_q, in_irq_d;
  logic       half_q;
  logic       wr_ok;

  psg_pkg::psg_ctrl_t ctrl;
  logic [psg_pkg::NumVoices-1:0][psg_pkg::ToneW-1:0] period;
  logic [psg_pkg::NumVoices-1:0] sync_set;
  logic [psg_pkg::NumVoices-1:0] edges;
  logic [psg_pkg::NumVoices-1:0][psg_pkg::LevelW-1:0] lvl;
  logic       noise_bit;
  logic [psg_pkg::LevelW-1:0] env_lvl;
  logic [7:0] rd_data;
  logic [7:0] vol;
  logic [7:0] mixer;

  // Input register; it moves on whenever the result register can take an item.
  assign adv        = !out_valid_q || !out_stall_i;
  assign exec       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      func_q  <= func_i;
      value_q <= value_i;
    end
  end

  assign wr_ok = exec && (func_q == psg_pkg::PSG_WRITE) && (sel_q < 8'(psg_pkg::RegCount));

  always_comb begin
    ctrl.tick        = exec && (func_q == psg_pkg::PSG_TICK);
    ctrl.half_tick   = ctrl.tick && !half_q;
    ctrl.irq_exit    = exec && (func_q == psg_pkg::PSG_IRQ_EXIT);
    ctrl.env_restart = wr_ok && (sel_q[3:0] == psg_pkg::REG_ENV_SHAPE);
  end

  always_comb begin
    for (int r = 0; r < psg_pkg::RegCount; r++) begin
      regs_d[r] = regs_q[r];
    end
    if (wr_ok) begin
      regs_d[sel_q[3:0]] = value_q & psg_pkg::reg_mask(sel_q[3:0]);
    end
    sel_d = (exec && func_q == psg_pkg::PSG_SELECT) ? value_q : sel_q;
    if (exec && func_q == psg_pkg::PSG_IRQ_ENTER) begin
      in_irq_d = 1'b1;
    end else if (ctrl.irq_exit) begin
      in_irq_d = 1'b0;
    end else begin
      in_irq_d = in_irq_q;
    end
    // A period write inside the interrupt that leaves the period at 0 or 1 arms sync.
    for (int v = 0; v < psg_pkg::NumVoices; v++) begin
      sync_set[v] = wr_ok && in_irq_q && (sel_q[7:1] == 7'(v)) &&
                    (regs_d[2*v+1][3:0] == 4'd0) && (regs_d[2*v][7:1] == 7'd0);
      period[v]   = {regs_q[2*v+1][3:0], regs_q[2*v]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < psg_pkg::RegCount; r++) begin
        regs_q[r] <= (r == int'(psg_pkg::REG_MIXER)) ? psg_pkg::MIXER_RESET : 8'h00;
      end
      sel_q    <= '0;
      in_irq_q <= 1'b0;
      half_q   <= 1'b0;
    end else begin
      for (int r = 0; r < psg_pkg::RegCount; r++) begin
        regs_q[r] <= regs_d[r];
      end
      sel_q    <= sel_d;
      in_irq_q <= in_irq_d;
      if (ctrl.tick) begin
        half_q <= ~half_q;
      end
    end
  end

  psg_tone u_tone (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .period_i   (period),
    .sync_set_i (sync_set),
    .edges_o    (edges)
  );

  psg_noise u_noise (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .period_i    (regs_q[psg_pkg::REG_NOISE][psg_pkg::NoiseW-1:0]),
    .noise_bit_o (noise_bit)
  );

  psg_env u_env (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .period_i ({regs_q[psg_pkg::REG_ENV_COARSE], regs_q[psg_pkg::REG_ENV_FINE]}),
    .shape_i  (regs_q[psg_pkg::REG_ENV_SHAPE][3:0]),
    .level_o  (env_lvl)
  );

  always_comb begin
    mixer = regs_q[psg_pkg::REG_MIXER];
    vol   = '0;
    for (int v = 0; v < psg_pkg::NumVoices; v++) begin
      vol    = regs_q[int'(psg_pkg::REG_VOL_A) + v];
      lvl[v] = '0;
      if (ctrl.tick && (edges[v] || mixer[v]) && (noise_bit || mixer[v+3])) begin
        lvl[v] = vol[4] ? env_lvl : vol[3:0];
      end
    end
    rd_data = '0;
    if (exec && func_q == psg_pkg::PSG_READ && sel_q < 8'(psg_pkg::RegCount)) begin
      rd_data = regs_q[sel_q[3:0]];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      level_a_q   <= lvl[0];
      level_b_q   <= lvl[1];
      level_c_q   <= lvl[2];
      read_data_q <= rd_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_a_o   = level_a_q;
  assign level_b_o   = level_b_q;
  assign level_c_o   = level_c_q;
  assign read_data_o = read_data_q;

  a_read_excludes_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && read_data_q != 8'd0 |->
      level_a_q == 4'd0 && level_b_q == 4'd0 && level_c_q == 4'd0)
    else $error("read result carries voice levels");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled while the result register could drain");

  a_no_write_past_file: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ok |-> sel_q[7:4] == 4'd0 && sel_q[3:0] != 4'd14 && sel_q[3:0] != 4'd15)
    else $error("write accepted for a register beyond the file");

  a_half_toggles_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.tick |=> half_q != $past(half_q))
    else $error("half-rate toggle missed a tick");

endmodule
